@@ rtl/ssk_pkg.sv @@
// Shared types, constants and the control program of the sorted store key delete unit.
`default_nettype none

package ssk_pkg;

   localparam int          ENTRIES_DEFAULT = 1024;
   localparam int          ADDR_W          = 10;
   localparam int          WORD_W          = 32;
   localparam int          COUNT_W         = 11;
   localparam int          KIND_W          = 2;
   localparam int          REQ_DATA_W      = 48;
   localparam int          RSP_DATA_W      = 48;
   localparam logic [WORD_W-1:0]  SENTINEL_WORD = 32'h8000_0000;
   localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

   // Item kinds carried in req_tuser
   localparam logic [KIND_W-1:0] REQ_WRITE  = 2'd0;
   localparam logic [KIND_W-1:0] REQ_DELETE = 2'd1;
   localparam logic [KIND_W-1:0] REQ_READ   = 2'd2;

   typedef enum logic [3:0] {
      STEP_CLEAR,
      STEP_IDLE,
      STEP_WRITE,
      STEP_READ_ADDR,
      STEP_READ_CAPTURE,
      STEP_DELETE_SETUP,
      STEP_SCAN,
      STEP_RUN,
      STEP_COPY,
      STEP_FILL,
      STEP_RESPOND
   } step_type;

   typedef enum logic [2:0] {
      TEST_NEVER,
      TEST_ALWAYS,
      TEST_IN_VALID,
      TEST_MATCH,
      TEST_END,
      TEST_STOP,
      TEST_DST_LAST,
      TEST_OUT_FREE
   } test_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_ITEM,
      WR_COPY,
      WR_SENTINEL
   } write_sel_type;

   typedef enum logic [1:0] {
      MARK_NONE,
      MARK_FIRST,
      MARK_MORE
   } mark_type;

   typedef struct packed {
      logic          in_ready;
      logic          stream_rd;
      logic          single_rd;
      logic          ptr_clr;
      logic          cap_read;
      logic          load_rsp;
      logic          dispatch;
      mark_type      mark;
      write_sel_type wr_sel;
      test_type      test_a;
      step_type      target_a;
      test_type      test_b;
      step_type      target_b;
      step_type      target_else;
   } ctrl_word_type;

   typedef struct packed {
      logic in_valid;
      logic match;
      logic at_end;
      logic stop;
      logic dst_last;
      logic out_free;
   } cond_type;

   typedef struct packed {
      step_type      step;
      step_type      next;
      ctrl_word_type ctrl;
   } seq_type;

   localparam ctrl_word_type CTRL_BASE = '{
      in_ready:    1'b0,
      stream_rd:   1'b0,
      single_rd:   1'b0,
      ptr_clr:     1'b0,
      cap_read:    1'b0,
      load_rsp:    1'b0,
      dispatch:    1'b0,
      mark:        MARK_NONE,
      wr_sel:      WR_NONE,
      test_a:      TEST_NEVER,
      target_a:    STEP_IDLE,
      test_b:      TEST_NEVER,
      target_b:    STEP_IDLE,
      target_else: STEP_IDLE
   };

   // Control program: one word per step
   function automatic ctrl_word_type ucode(step_type step);
      ctrl_word_type w;
      w = CTRL_BASE;
      unique case (step)
         STEP_CLEAR: begin
            w.wr_sel      = WR_SENTINEL;
            w.test_a      = TEST_DST_LAST;
            w.target_a    = STEP_IDLE;
            w.target_else = STEP_CLEAR;
         end
         STEP_IDLE: begin
            w.in_ready    = 1'b1;
            w.dispatch    = 1'b1;
            w.test_a      = TEST_IN_VALID;
            w.target_else = STEP_IDLE;
         end
         STEP_WRITE: begin
            w.wr_sel      = WR_ITEM;
            w.target_else = STEP_RESPOND;
         end
         STEP_READ_ADDR: begin
            w.single_rd   = 1'b1;
            w.target_else = STEP_READ_CAPTURE;
         end
         STEP_READ_CAPTURE: begin
            w.cap_read    = 1'b1;
            w.target_else = STEP_RESPOND;
         end
         STEP_DELETE_SETUP: begin
            w.ptr_clr     = 1'b1;
            w.target_else = STEP_SCAN;
         end
         STEP_SCAN: begin
            w.stream_rd   = 1'b1;
            w.mark        = MARK_FIRST;
            w.test_a      = TEST_MATCH;
            w.target_a    = STEP_RUN;
            w.test_b      = TEST_END;
            w.target_b    = STEP_RESPOND;
            w.target_else = STEP_SCAN;
         end
         STEP_RUN: begin
            w.stream_rd   = 1'b1;
            w.mark        = MARK_MORE;
            w.wr_sel      = WR_COPY;
            w.test_a      = TEST_MATCH;
            w.target_a    = STEP_RUN;
            w.test_b      = TEST_STOP;
            w.target_b    = STEP_FILL;
            w.target_else = STEP_COPY;
         end
         STEP_COPY: begin
            w.stream_rd   = 1'b1;
            w.wr_sel      = WR_COPY;
            w.test_a      = TEST_STOP;
            w.target_a    = STEP_FILL;
            w.target_else = STEP_COPY;
         end
         STEP_FILL: begin
            w.wr_sel      = WR_SENTINEL;
            w.test_a      = TEST_DST_LAST;
            w.target_a    = STEP_RESPOND;
            w.target_else = STEP_FILL;
         end
         STEP_RESPOND: begin
            w.load_rsp    = 1'b1;
            w.test_a      = TEST_OUT_FREE;
            w.target_a    = STEP_IDLE;
            w.target_else = STEP_RESPOND;
         end
         default: begin
            w.target_else = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   // Jump table for an accepted item
   function automatic step_type dispatch_step(logic [KIND_W-1:0] kind);
      step_type s;
      unique case (kind)
         REQ_WRITE:  s = STEP_WRITE;
         REQ_DELETE: s = STEP_DELETE_SETUP;
         REQ_READ:   s = STEP_READ_ADDR;
         default:    s = STEP_RESPOND;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

@@ rtl/ssk_store.sv @@
// Entry store: one write port and one read port with registered read data.
`default_nettype none

module ssk_store import ssk_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEFAULT,
   parameter int AW      = $clog2(ENTRIES)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [WORD_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output      logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [ENTRIES];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/ssk_sequencer.sv @@
// Step counter, control word fetch and conditional jumps.
`default_nettype none

module ssk_sequencer import ssk_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [KIND_W-1:0] kind,
   input  wire cond_type          cond,
   output      seq_type           seq
);

   step_type      step_ff;
   step_type      step_in;
   ctrl_word_type ctrl;

   function automatic logic test_true(test_type t, cond_type c);
      logic r;
      unique case (t)
         TEST_NEVER:    r = 1'b0;
         TEST_ALWAYS:   r = 1'b1;
         TEST_IN_VALID: r = c.in_valid;
         TEST_MATCH:    r = c.match;
         TEST_END:      r = c.at_end;
         TEST_STOP:     r = c.stop;
         TEST_DST_LAST: r = c.dst_last;
         TEST_OUT_FREE: r = c.out_free;
         default:       r = 1'b0;
      endcase
      return r;
   endfunction

   // Fetch
   always_comb begin
      ctrl = ucode(step_ff);
   end

   // Branch
   always_comb begin
      if (test_true(ctrl.test_a, cond)) begin
         step_in = ctrl.dispatch ? dispatch_step(kind) : ctrl.target_a;
      end else if (test_true(ctrl.test_b, cond)) begin
         step_in = ctrl.target_b;
      end else begin
         step_in = ctrl.target_else;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

   assign seq.step = step_ff;
   assign seq.next = step_in;
   assign seq.ctrl = ctrl;

endmodule

`default_nettype wire

@@ rtl/sorted_store_key_delete_unit.sv @@
// Top level of the sorted store key delete unit: datapath around the store and sequencer.
`default_nettype none

//  channel  dir  handshake                fields (lowest bit up)
//  req      in   req_tvalid / req_tready  tuser: req_type[1:0]
//                                         tdata: address[9:0], data_word[41:10]
//  rsp      out  rsp_tvalid / rsp_tready  tdata: read_word[31:0], key_found[32],
//                                                removed_count[43:33]
//
//  A write passes the steps WRITE and RESPOND; a read passes READ_ADDR,
//  READ_CAPTURE and RESPOND (the store's registered read port sets this).
//  A delete makes one streaming pass that reads the store one entry a cycle while
//  copying behind the read pointer, then the sentinel fill writes one entry a
//  cycle down to the end of the store. After reset a clearing pass writes the
//  sentinel to every entry; no beat is taken on req until it ends.
//  A finished result waits in the output register; the next beat on req is taken
//  meanwhile, and its result is held back until the register is free.

module sorted_store_key_delete_unit import ssk_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [KIND_W-1:0]     req_tuser,   // req_type[1:0]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // address[9:0], data_word[41:10]
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata    // read_word[31:0], key_found[32],
                                                   // removed_count[43:33]
);

   localparam int AW = $clog2(ENTRIES);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] PTR_END  = CW'(ENTRIES);
   localparam logic [CW-1:0] PTR_LAST = CW'(ENTRIES - 1);

   seq_type  seq;
   cond_type cond;

   // Item registers
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [WORD_W-1:0] key_ff,  key_in;

   // Stream pointers
   logic [CW-1:0] rp_ff,  rp_in;
   logic [CW-1:0] dst_ff, dst_in;
   logic [AW-1:0] ri_ff,  ri_in;
   logic          rv_ff,  rv_in;

   // Result under construction
   logic [WORD_W-1:0]  rd_word_ff, rd_word_in;
   logic               found_ff,   found_in;
   logic [COUNT_W-1:0] count_ff,   count_in;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff,  rsp_data_in;

   // Store ports
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [WORD_W-1:0] rd_data;

   logic accept;
   logic addr_ok;
   logic rp_live;
   logic load_rsp;

   assign accept   = req_tvalid && req_tready;
   assign addr_ok  = 32'(addr_ff) < 32'(ENTRIES);
   assign rp_live  = rp_ff < PTR_END;
   assign load_rsp = seq.ctrl.load_rsp && cond.out_free;

   // Conditions for the sequencer; a missing read beat in a pass means the end
   always_comb begin
      cond.in_valid = req_tvalid;
      cond.match    = rv_ff && (rd_data == key_ff);
      cond.at_end   = !rv_ff && (rp_ff == PTR_END);
      cond.stop     = !rv_ff || (rd_data == SENTINEL_WORD);
      cond.dst_last = dst_ff == PTR_LAST;
      cond.out_free = !rsp_valid_ff || rsp_tready;
   end

   ssk_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .kind  (req_tuser),
      .cond  (cond),
      .seq   (seq)
   );

   ssk_store #(
      .ENTRIES (ENTRIES),
      .AW      (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = seq.ctrl.in_ready;

   // Store write port: item write, copy behind the read pointer, or sentinel fill
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = dst_ff[AW-1:0];
      wr_data = SENTINEL_WORD;
      case (seq.ctrl.wr_sel)
         WR_ITEM: begin
            wr_en   = addr_ok;
            wr_addr = AW'(addr_ff);
            wr_data = key_ff;
         end
         WR_COPY: begin
            // copy only when the step goes on copying
            wr_en   = seq.next == STEP_COPY;
            wr_data = rd_data;
         end
         WR_SENTINEL: begin
            wr_en   = 1'b1;
         end
         default: begin
            wr_en   = 1'b0;
         end
      endcase
   end

   // Store read port: single read at the item address or the stream pointer
   always_comb begin
      rd_en   = seq.ctrl.single_rd || (seq.ctrl.stream_rd && rp_live);
      rd_addr = seq.ctrl.single_rd ? AW'(addr_ff) : rp_ff[AW-1:0];
   end

   // Datapath next state
   always_comb begin
      addr_in    = addr_ff;
      key_in     = key_ff;
      rp_in      = rp_ff;
      dst_in     = dst_ff;
      ri_in      = ri_ff;
      rv_in      = seq.ctrl.stream_rd && rp_live;
      rd_word_in = rd_word_ff;
      found_in   = found_ff;
      count_in   = count_ff;

      if (accept) begin
         addr_in    = req_tdata[ADDR_W-1:0];
         key_in     = req_tdata[ADDR_W +: WORD_W];
         rd_word_in = '0;
         found_in   = 1'b0;
         count_in   = '0;
      end

      if (seq.ctrl.ptr_clr) begin
         rp_in  = '0;
         dst_in = '0;
      end

      // advance the stream; the data of index ri arrives in the cycle after the read
      if (seq.ctrl.stream_rd && rp_live) begin
         ri_in = rp_ff[AW-1:0];
         rp_in = rp_ff + CW'(1);
      end

      if (cond.match) begin
         case (seq.ctrl.mark)
            MARK_FIRST: begin
               found_in = 1'b1;
               count_in = COUNT_W'(1);
               dst_in   = CW'(ri_ff);
            end
            MARK_MORE: begin
               // saturate the count
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end

      if (wr_en && (seq.ctrl.wr_sel == WR_COPY || seq.ctrl.wr_sel == WR_SENTINEL)) begin
         dst_in = dst_ff + CW'(1);
      end

      if (seq.ctrl.cap_read) begin
         rd_word_in = addr_ok ? rd_data : '0;
      end
   end

   // Output register: load when free, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {(RSP_DATA_W - WORD_W - 1 - COUNT_W)'(0), count_ff, found_ff,
                         rd_word_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff        <= '0;
         dst_ff       <= '0;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rp_ff        <= rp_in;
         dst_ff       <= dst_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      key_ff      <= key_in;
      ri_ff       <= ri_in;
      rd_word_ff  <= rd_word_in;
      found_ff    <= found_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Copies always land below the read pointer
   a_copy_behind: assert property (@(posedge clock) disable iff (reset)
      (wr_en && seq.ctrl.wr_sel == WR_COPY) |-> (dst_ff < rp_ff))
      else $error("copy write at or above read pointer");

   // Sentinel writes stay inside the store
   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      (seq.step == STEP_FILL || seq.step == STEP_CLEAR) |-> (dst_ff < PTR_END))
      else $error("sentinel fill beyond the store");

   // A found key always removes at least one entry
   a_found_count: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (count_ff != '0))
      else $error("key found with zero count");

   // One item at a time: no beat is taken in the cycle after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("second beat taken while an item is in work");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench of the sorted store key delete unit over its req and rsp streams.
`timescale 1ns / 100ps

module tb_top;
   import ssk_pkg::*;

   localparam int                STORE_DEPTH = ENTRIES_DEFAULT;
   localparam logic [KIND_W-1:0] REQ_UNUSED  = 2'd3;
   localparam logic [WORD_W-1:0] WORD_MAX    = 32'h7FFF_FFFF;
   // Slowest correct run: every item a full-length delete with long gaps on both
   // sides, after the clearing pass; then taken four times over.
   localparam int                CYCLE_LIMIT = 3_000_000;

   // One result beat, fields as they sit in rsp_tdata from the highest bit down
   typedef struct packed {
      logic [COUNT_W-1:0] removed_count;
      logic               key_found;
      logic [WORD_W-1:0]  read_word;
   } result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [KIND_W-1:0]     req_tuser  = '0;   // req_type[1:0]
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // address[9:0], data_word[41:10]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // read_word[31:0], key_found[32],
                                             // removed_count[43:33]

   // Predicted copy of the store and the results still owed by the block
   logic [WORD_W-1:0] store_words [STORE_DEPTH];
   result_type        pending_results [$];
   result_type        oldest;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int sent_items    = 0;
   int errors        = 0;
   int cycle_count   = 0;

   sorted_store_key_delete_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Apply one accepted item to the predicted store and return the result it owes.
   function automatic result_type apply_item(logic [KIND_W-1:0] kind,
                                             logic [ADDR_W-1:0] addr,
                                             logic [WORD_W-1:0] word);
      result_type res;
      int         lead;
      int         src;
      int         dst;
      bit         hit;
      res = '0;
      if (kind == REQ_WRITE) begin
         if (addr < STORE_DEPTH) store_words[addr] = word;
      end else if (kind == REQ_READ) begin
         if (addr < STORE_DEPTH) res.read_word = store_words[addr];
      end else if (kind == REQ_DELETE) begin
         // find the lowest match
         lead = 0;
         hit  = 1'b0;
         while (lead < STORE_DEPTH && !hit) begin
            if (store_words[lead] == word) hit = 1'b1;
            else lead++;
         end
         if (hit) begin
            // skip the run of equal entries; only this block goes, later copies stay
            src = lead + 1;
            while (src < STORE_DEPTH && store_words[src] == word) src++;
            res.key_found     = 1'b1;
            res.removed_count = (src - lead > COUNT_MAX) ? COUNT_MAX : COUNT_W'(src - lead);
            // compact the tail down over the run, stopping at the first sentinel
            dst = lead;
            while (src < STORE_DEPTH && store_words[src] != SENTINEL_WORD) begin
               store_words[dst] = store_words[src];
               dst++;
               src++;
            end
            // anything beyond the new end, including words past a sentinel, is lost
            while (dst < STORE_DEPTH) begin
               store_words[dst] = SENTINEL_WORD;
               dst++;
            end
         end
      end
      return res;
   endfunction

   // Offer one beat on req and hold it until taken. tvalid is left high after the
   // handshake so that a back-to-back beat never lowers and raises it in one step.
   task automatic send_item(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                            logic [WORD_W-1:0] word);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_DATA_W - ADDR_W - WORD_W){1'b0}}, word, addr};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(apply_item(kind, addr, word));
      sent_items++;
   endtask

   // Hold off the sender until every owed result has arrived
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic set_idling(int send_pct, int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // Receiver: stall at the rate of the current phase
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Compare each result beat with the oldest prediction, field by field
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result beat with no prediction waiting: tdata %h", rsp_tdata);
            errors++;
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_tdata[31:0] !== oldest.read_word) begin
               $error("read_word: expected %h, got %h", oldest.read_word, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[32] !== oldest.key_found) begin
               $error("key_found: expected %b, got %b", oldest.key_found, rsp_tdata[32]);
               errors++;
            end
            if (rsp_tdata[43:33] !== oldest.removed_count) begin
               $error("removed_count: expected %0d, got %0d", oldest.removed_count,
                      rsp_tdata[43:33]);
               errors++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sorted_store_key_delete_unit regression: fail");
         $finish;
      end
   end

   // Store straight after reset: all sentinel, so deleting the sentinel takes every entry
   task automatic test_reset_contents();
      send_item(REQ_READ, 10'd0, 32'd0);
      send_item(REQ_DELETE, 10'd0, SENTINEL_WORD);
   endtask

   // Unused kind: nothing happens and the result is all zeros
   task automatic test_unused_kind();
      send_item(REQ_UNUSED, '1, '1);
      send_item(REQ_UNUSED, '0, '0);
   endtask

   // Run near the top of the store: the copy stops at the end of the store
   task automatic test_tail_to_store_end();
      send_item(REQ_WRITE, 10'd1020, 32'd5);
      send_item(REQ_WRITE, 10'd1021, 32'd5);
      send_item(REQ_WRITE, 10'd1022, 32'd7);
      send_item(REQ_WRITE, 10'd1023, WORD_MAX);
      send_item(REQ_DELETE, 10'd0, 32'd5);
      send_item(REQ_READ, 10'd1021, 32'd0);
      send_item(REQ_READ, 10'd1022, 32'd0);
   endtask

   // Key absent: no change and a zero result
   task automatic test_missing_key();
      send_item(REQ_DELETE, 10'd0, 32'd12345);
   endtask

   // Unsorted store: a later copy of the key stays, words past a sentinel are lost
   task automatic test_unsorted_and_lost_tail();
      send_item(REQ_WRITE, 10'd0, 32'd3);
      send_item(REQ_WRITE, 10'd1, 32'd3);
      send_item(REQ_WRITE, 10'd2, 32'd9);
      send_item(REQ_WRITE, 10'd3, 32'd3);
      send_item(REQ_WRITE, 10'd5, 32'd11);
      send_item(REQ_DELETE, 10'd0, 32'd3);
      send_item(REQ_READ, 10'd1, 32'd0);
      send_item(REQ_READ, 10'd5, 32'd0);
   endtask

   // Sentinel as a key once the store holds real words ahead of it
   task automatic test_sentinel_key();
      send_item(REQ_DELETE, 10'd0, SENTINEL_WORD);
   endtask

   // Extremes of the word: largest positive and all ones
   task automatic test_word_extremes();
      send_item(REQ_WRITE, 10'd0, WORD_MAX);
      send_item(REQ_WRITE, 10'd1, '1);
      send_item(REQ_DELETE, 10'd0, '1);
      send_item(REQ_READ, 10'd0, 32'd0);
   endtask

   // Load a short sorted run at the bottom of the store, close it with a sentinel,
   // then delete some of its keys (now and then an absent one) and read back.
   task automatic run_sorted_batch();
      logic [WORD_W-1:0] run_words [12];
      logic [WORD_W-1:0] word;
      int                n;
      n    = $urandom_range(1, 12);
      word = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 63) - 32;
      for (int k = 0; k < n; k++) begin
         run_words[k] = word;
         send_item(REQ_WRITE, ADDR_W'(k), word);
         word = word + $urandom_range(0, 2);
      end
      send_item(REQ_WRITE, ADDR_W'(n), SENTINEL_WORD);
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(0, 4) == 0) word = $urandom;
         else word = run_words[$urandom_range(0, n - 1)];
         send_item(REQ_DELETE, 10'($urandom), word);
      end
      repeat ($urandom_range(0, 3)) send_item(REQ_READ, ADDR_W'($urandom_range(0, n)), $urandom);
   endtask

   // Noise: any kind, any address, any word; deletes often aim at a stored word
   task automatic send_noise_item();
      logic [KIND_W-1:0] kind;
      logic [WORD_W-1:0] word;
      kind = KIND_W'($urandom_range(0, 3));
      word = $urandom;
      if (kind == REQ_DELETE && $urandom_range(0, 1)) word = store_words[$urandom_range(0, 15)];
      send_item(kind, ADDR_W'($urandom), word);
   endtask

   task automatic test_random_traffic(int items);
      int stop_at;
      stop_at = sent_items + items;
      while (sent_items < stop_at) begin
         if ($urandom_range(0, 9) < 7) run_sorted_batch();
         else send_noise_item();
      end
   endtask

   initial begin
      foreach (store_words[i]) store_words[i] = SENTINEL_WORD;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_contents();
      test_unused_kind();
      test_tail_to_store_end();
      test_missing_key();
      test_unsorted_and_lost_tail();
      test_sentinel_key();
      test_word_extremes();
      drain_results();

      // Random traffic through every idling phase, draining between them
      set_idling(0, 0);
      test_random_traffic(60);
      drain_results();
      set_idling(45, 0);
      test_random_traffic(60);
      drain_results();
      set_idling(0, 45);
      test_random_traffic(60);
      drain_results();
      set_idling(29, 29);
      test_random_traffic(60);
      drain_results();

      // Let a full delete's worth of cycles pass to catch stray result beats
      repeat (2 * STORE_DEPTH + 16) @(posedge clock);
      if (errors == 0) begin
         $display("sorted_store_key_delete_unit regression: pass");
      end else begin
         $display("sorted_store_key_delete_unit regression: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/ssk_pkg.sv
rtl/ssk_store.sv
rtl/ssk_sequencer.sv
rtl/sorted_store_key_delete_unit.sv
test/tb_top.sv
